### design/kmu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kmu_pkg;

  localparam int STATES_DEF = 4;
  localparam int OBS_DEF    = 6;
  localparam int VW         = 32;
  localparam int FRAC       = 24;

  typedef struct packed {
    logic [2:0]        kind;
    logic [2:0]        row;
    logic [2:0]        col;
    logic signed [31:0] value;
    logic              predict_only;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         state_index;
    logic signed [31:0] correction;
    logic               singular;
    logic               last;
  } result_t;

  localparam logic [2:0] KIND_PHI = 3'd0;
  localparam logic [2:0] KIND_H   = 3'd1;
  localparam logic [2:0] KIND_Z   = 3'd2;
  localparam logic [2:0] KIND_R   = 3'd3;
  localparam logic [2:0] KIND_Q   = 3'd4;
  localparam logic [2:0] KIND_P   = 3'd5;
  localparam logic [2:0] KIND_RUN = 3'd6;

  // Microcode operations.
  localparam logic [3:0] OP_MM_A    = 4'd0;
  localparam logic [3:0] OP_MM_PM   = 4'd1;
  localparam logic [3:0] OP_MM_G    = 4'd2;
  localparam logic [3:0] OP_MM_W    = 4'd3;
  localparam logic [3:0] OP_IDENT   = 4'd4;
  localparam logic [3:0] OP_COL0    = 4'd5;
  localparam logic [3:0] OP_PIVOT   = 4'd6;
  localparam logic [3:0] OP_NOP     = 4'd7;
  localparam logic [3:0] OP_SWAP    = 4'd8;
  localparam logic [3:0] OP_NORM    = 4'd9;
  localparam logic [3:0] OP_ELIM    = 4'd10;
  localparam logic [3:0] OP_NEXTCOL = 4'd11;
  localparam logic [3:0] OP_MM_KG   = 4'd12;
  localparam logic [3:0] OP_MM_CORR = 4'd13;
  localparam logic [3:0] OP_MM_P    = 4'd14;
  localparam logic [3:0] OP_EMIT    = 4'd15;

  localparam logic [1:0] COND_NONE = 2'd0;
  localparam logic [1:0] COND_SING = 2'd1;
  localparam logic [1:0] COND_COLS = 2'd2;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] cond;
    logic [3:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [3:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_NONE, target: 4'd0};
    unique case (pc)
      4'd0:  w = '{op: OP_MM_A,    cond: COND_NONE, target: 4'd0};
      4'd1:  w = '{op: OP_MM_PM,   cond: COND_NONE, target: 4'd0};
      4'd2:  w = '{op: OP_MM_G,    cond: COND_NONE, target: 4'd0};
      4'd3:  w = '{op: OP_MM_W,    cond: COND_NONE, target: 4'd0};
      4'd4:  w = '{op: OP_IDENT,   cond: COND_NONE, target: 4'd0};
      4'd5:  w = '{op: OP_COL0,    cond: COND_NONE, target: 4'd0};
      4'd6:  w = '{op: OP_PIVOT,   cond: COND_NONE, target: 4'd0};
      4'd7:  w = '{op: OP_NOP,     cond: COND_SING, target: 4'd12};
      4'd8:  w = '{op: OP_SWAP,    cond: COND_NONE, target: 4'd0};
      4'd9:  w = '{op: OP_NORM,    cond: COND_NONE, target: 4'd0};
      4'd10: w = '{op: OP_ELIM,    cond: COND_NONE, target: 4'd0};
      4'd11: w = '{op: OP_NEXTCOL, cond: COND_COLS, target: 4'd6};
      4'd12: w = '{op: OP_MM_KG,   cond: COND_NONE, target: 4'd0};
      4'd13: w = '{op: OP_MM_CORR, cond: COND_NONE, target: 4'd0};
      4'd14: w = '{op: OP_MM_P,    cond: COND_NONE, target: 4'd0};
      4'd15: w = '{op: OP_EMIT,    cond: COND_NONE, target: 4'd0};
      default: w = '{op: OP_NOP, cond: COND_NONE, target: 4'd0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### design/kmu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module kmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/kmu_div.sv
`timescale 1ns / 1ps
`default_nettype none
module kmu_div import kmu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [VW-1:0] num,
  input  wire logic signed [VW-1:0] den,
  output logic                    done,
  output logic signed [VW-1:0]    quo
);

  localparam int NW = VW + FRAC;
  localparam int CW = $clog2(NW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [VW:0]   rem;
  logic [VW:0]   dsr;
  logic [NW-1:0] dvd;
  logic [NW-1:0] qm;
  logic          neg;
  logic [VW-1:0] amag;
  logic [VW-1:0] bmag;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_next;
  logic          qbit;
  logic          over_p;
  logic          over_n;

  assign amag     = num[VW-1] ? (~num + 1'b1) : num;
  assign bmag     = den[VW-1] ? (~den + 1'b1) : den;
  assign rem_sh   = {rem[VW-1:0], dvd[NW-1]};
  assign qbit     = (rem_sh >= dsr);
  assign rem_next = qbit ? (rem_sh - dsr) : rem_sh;

  // Magnitude limits of the signed result: 2^31-1 upward, 2^31 downward.
  assign over_p = |qm[NW-1:VW-1];
  assign over_n = (|qm[NW-1:VW]) || (qm[VW-1] && (|qm[VW-2:0]));

  always_comb begin
    if (neg) begin
      quo = over_n ? {1'b1, {(VW-1){1'b0}}} : (~qm[VW-1:0] + 1'b1);
    end else begin
      quo = over_p ? {1'b0, {(VW-1){1'b1}}} : qm[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        rem <= '0;
        dvd <= {amag, {FRAC{1'b0}}};
        dsr <= {1'b0, bmag};
        neg <= num[VW-1] ^ den[VW-1];
        qm  <= '0;
      end else if (run) begin
        rem <= rem_next;
        dvd <= {dvd[NW-2:0], 1'b0};
        qm  <= {qm[NW-2:0], qbit};
        cnt <= cnt + CW'(1);
        if (int'(cnt) + 1 == NW) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### design/kalman_measurement_update_4x6_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                    Word
// command   start, busy, cmd         cmd_t: load one element or run an update
// result    strobe, result           result_t: one state correction per strobe
//
// A load writes its element while idle and leaves busy low. A run raises busy until its
// last result goes out. In the matrix products each multiply-add passes through RA, RB,
// MUL and ACC on the single read port of the work RAM. With 4 states and 6 observations,
// each of the 72 elements of the pivot rows waits on the serial divider in the inversion,
// rows are swapped where the pivot search asks for it, and a zero pivot skips the rest of it.
// Reset clears the sequencer and marks the covariance as zero.
// The four results of a run come one per strobe and cannot be held off.
module kalman_measurement_update_4x6_core import kmu_pkg::*; #(
  parameter int STATES       = STATES_DEF,
  parameter int OBSERVATIONS = OBS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      strobe,
  output result_t   result
);

  localparam int NS   = STATES;
  localparam int NO   = OBSERVATIONS;
  localparam int NS2  = NS * NS;
  localparam int NC   = 2 * NO;
  localparam int MAXD = (NC > NS) ? NC : NS;
  localparam int IW   = $clog2(MAXD + 1);
  localparam int PVW  = (NS2 > 1) ? $clog2(NS2) : 1;

  localparam int B_P   = 0;
  localparam int B_PHI = B_P + NS2;
  localparam int B_Q   = B_PHI + NS2;
  localparam int B_H   = B_Q + NS2;
  localparam int B_R   = B_H + NO * NS;
  localparam int B_Z   = B_R + NO * NO;
  localparam int B_A   = B_Z + NO;
  localparam int B_PM  = B_A + NS2;
  localparam int B_G   = B_PM + NS2;
  localparam int B_M   = B_G + NS * NO;
  localparam int B_KG  = B_M + NO * NC;
  localparam int B_CR  = B_KG + NS * NO;
  localparam int DEPTH = B_CR + NS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_FETCH   = 5'd1;
  localparam logic [4:0] S_NEXT    = 5'd2;
  localparam logic [4:0] S_RI      = 5'd3;
  localparam logic [4:0] S_RIC     = 5'd4;
  localparam logic [4:0] S_RA      = 5'd5;
  localparam logic [4:0] S_RB      = 5'd6;
  localparam logic [4:0] S_MUL     = 5'd7;
  localparam logic [4:0] S_ACC     = 5'd8;
  localparam logic [4:0] S_WR      = 5'd9;
  localparam logic [4:0] S_PV_RD   = 5'd10;
  localparam logic [4:0] S_PV_CMP  = 5'd11;
  localparam logic [4:0] S_PV_END  = 5'd12;
  localparam logic [4:0] S_SW_R1   = 5'd13;
  localparam logic [4:0] S_SW_R2   = 5'd14;
  localparam logic [4:0] S_SW_W1   = 5'd15;
  localparam logic [4:0] S_SW_W2   = 5'd16;
  localparam logic [4:0] S_NM_RP   = 5'd17;
  localparam logic [4:0] S_NM_PV   = 5'd18;
  localparam logic [4:0] S_NM_RD   = 5'd19;
  localparam logic [4:0] S_NM_GO   = 5'd20;
  localparam logic [4:0] S_NM_WAIT = 5'd21;
  localparam logic [4:0] S_NM_WR   = 5'd22;
  localparam logic [4:0] S_EL_RF   = 5'd23;
  localparam logic [4:0] S_EL_F    = 5'd24;
  localparam logic [4:0] S_EL_RM   = 5'd25;
  localparam logic [4:0] S_EL_RC   = 5'd26;
  localparam logic [4:0] S_EL_MUL  = 5'd27;
  localparam logic [4:0] S_EL_WR   = 5'd28;
  localparam logic [4:0] S_EM_RD   = 5'd29;
  localparam logic [4:0] S_EM_OUT  = 5'd30;

  logic [4:0]         state;
  logic [3:0]         pc;
  logic [3:0]         op;
  uword_t             uw;
  logic [IW-1:0]      i, j, k, r, col, best;
  logic [32:0]        best_mag;
  logic [32:0]        mag;
  logic signed [47:0] acc;
  logic signed [31:0] opa, mrk, f, piv, t1;
  logic signed [63:0] prod;
  logic               bzero;
  logic               singular;
  logic               po;
  logic [NS2-1:0]     pvalid;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rdata;

  logic               div_start, div_done;
  logic signed [31:0] div_q;

  int                 lim_i, lim_j, lim_k;
  logic               init_mem, init_id, sub;
  int                 a_ad, b_ad, i_ad, d_ad;
  logic [PVW-1:0]     pidx;

  logic               ld_ok;
  int                 ld_ad;

  function automatic logic signed [47:0] mulq(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd8388608;
    return 48'(t >>> FRAC);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    if (x > 48'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -48'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  kmu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  kmu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rdata),
    .den   (piv),
    .done  (div_done),
    .quo   (div_q)
  );

  assign uw        = ucode(pc);
  assign busy      = (state != S_IDLE);
  assign div_start = (state == S_NM_GO);
  assign mag       = rdata[31] ? (33'd0 - {rdata[31], rdata}) : {1'b0, rdata};
  assign pidx      = PVW'(int'(k) * NS + int'(j));

  // Loop bounds and address maps of the matrix products.
  always_comb begin
    lim_i = NS; lim_j = NS; lim_k = NS;
    init_mem = 1'b0; init_id = 1'b0; sub = 1'b0;
    a_ad = 0; b_ad = 0; i_ad = 0; d_ad = 0;
    unique case (op)
      OP_MM_A: begin
        a_ad = B_PHI + int'(i) * NS + int'(k);
        b_ad = B_P + int'(k) * NS + int'(j);
        d_ad = B_A + int'(i) * NS + int'(j);
      end
      OP_MM_PM: begin
        init_mem = 1'b1;
        i_ad = B_Q + int'(i) * NS + int'(j);
        a_ad = B_A + int'(i) * NS + int'(k);
        b_ad = B_PHI + int'(j) * NS + int'(k);
        d_ad = B_PM + int'(i) * NS + int'(j);
      end
      OP_MM_G: begin
        lim_j = NO;
        a_ad = B_PM + int'(i) * NS + int'(k);
        b_ad = B_H + int'(j) * NS + int'(k);
        d_ad = B_G + int'(i) * NO + int'(j);
      end
      OP_MM_W: begin
        lim_i = NO; lim_j = NO;
        init_mem = 1'b1;
        i_ad = B_R + int'(i) * NO + int'(j);
        a_ad = B_H + int'(i) * NS + int'(k);
        b_ad = B_G + int'(k) * NO + int'(j);
        d_ad = B_M + int'(i) * NC + int'(j);
      end
      OP_IDENT: begin
        lim_i = NO; lim_j = NO; lim_k = 0;
        init_id = 1'b1;
        d_ad = B_M + int'(i) * NC + NO + int'(j);
      end
      OP_MM_KG: begin
        lim_j = NO; lim_k = NO;
        a_ad = B_G + int'(i) * NO + int'(k);
        b_ad = B_M + int'(k) * NC + NO + int'(j);
        d_ad = B_KG + int'(i) * NO + int'(j);
      end
      OP_MM_CORR: begin
        lim_j = 1; lim_k = NO;
        a_ad = B_KG + int'(i) * NO + int'(k);
        b_ad = B_Z + int'(k);
        d_ad = B_CR + int'(i);
      end
      OP_MM_P: begin
        lim_k = NO;
        init_mem = 1'b1; sub = 1'b1;
        i_ad = B_PM + int'(i) * NS + int'(j);
        a_ad = B_KG + int'(i) * NO + int'(k);
        b_ad = B_G + int'(j) * NO + int'(k);
        d_ad = B_P + int'(i) * NS + int'(j);
      end
      default: ;
    endcase
  end

  always_comb begin
    ld_ok = 1'b0;
    ld_ad = 0;
    case (cmd.kind)
      KIND_PHI: begin
        ld_ok = (int'(cmd.row) < NS) && (int'(cmd.col) < NS);
        ld_ad = B_PHI + int'(cmd.row) * NS + int'(cmd.col);
      end
      KIND_H: begin
        ld_ok = (int'(cmd.row) < NO) && (int'(cmd.col) < NS);
        ld_ad = B_H + int'(cmd.row) * NS + int'(cmd.col);
      end
      KIND_Z: begin
        ld_ok = (int'(cmd.row) < NO);
        ld_ad = B_Z + int'(cmd.row);
      end
      KIND_R: begin
        ld_ok = (int'(cmd.row) < NO) && (int'(cmd.col) < NO);
        ld_ad = B_R + int'(cmd.row) * NO + int'(cmd.col);
      end
      KIND_Q: begin
        ld_ok = (int'(cmd.row) < NS) && (int'(cmd.col) < NS);
        ld_ad = B_Q + int'(cmd.row) * NS + int'(cmd.col);
      end
      KIND_P: begin
        ld_ok = (int'(cmd.row) < NS) && (int'(cmd.col) < NS);
        ld_ad = B_P + int'(cmd.row) * NS + int'(cmd.col);
      end
      default: ;
    endcase
  end

  // RAM port steering.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state)
      S_IDLE: begin
        we    = start && ld_ok;
        waddr = AW'(ld_ad);
        wdata = cmd.value;
      end
      S_RI:     raddr = AW'(i_ad);
      S_RA:     raddr = AW'(a_ad);
      S_RB:     raddr = AW'(b_ad);
      S_WR: begin
        we    = 1'b1;
        waddr = AW'(d_ad);
        wdata = sat32(acc);
      end
      S_PV_RD:  raddr = AW'(B_M + int'(r) * NC + int'(col));
      S_SW_R1:  raddr = AW'(B_M + int'(col) * NC + int'(k));
      S_SW_R2:  raddr = AW'(B_M + int'(best) * NC + int'(k));
      S_SW_W1: begin
        we    = 1'b1;
        waddr = AW'(B_M + int'(col) * NC + int'(k));
        wdata = rdata;
      end
      S_SW_W2: begin
        we    = 1'b1;
        waddr = AW'(B_M + int'(best) * NC + int'(k));
        wdata = t1;
      end
      S_NM_RP:  raddr = AW'(B_M + int'(col) * NC + int'(col));
      S_NM_RD:  raddr = AW'(B_M + int'(col) * NC + int'(k));
      S_NM_WR: begin
        we    = 1'b1;
        waddr = AW'(B_M + int'(col) * NC + int'(k));
        wdata = div_q;
      end
      S_EL_RF:  raddr = AW'(B_M + int'(r) * NC + int'(col));
      S_EL_RM:  raddr = AW'(B_M + int'(r) * NC + int'(k));
      S_EL_RC:  raddr = AW'(B_M + int'(col) * NC + int'(k));
      S_EL_WR: begin
        we    = 1'b1;
        waddr = AW'(B_M + int'(r) * NC + int'(k));
        wdata = sat32(48'(mrk) - mulq(prod));
      end
      S_EM_RD:  raddr = AW'(B_CR + int'(i));
      default: ;
    endcase
  end

  assign strobe               = (state == S_EM_OUT);
  assign result.state_index   = i[1:0];
  assign result.correction    = po ? 32'sd0 : rdata;
  assign result.singular      = singular;
  assign result.last          = (int'(i) + 1 == NS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pc       <= '0;
      singular <= 1'b0;
      pvalid   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (cmd.kind == KIND_P && ld_ok) begin
              pvalid[PVW'(int'(cmd.row) * NS + int'(cmd.col))] <= 1'b1;
            end
            if (cmd.kind == KIND_RUN) begin
              po       <= cmd.predict_only;
              singular <= 1'b0;
              pc       <= '0;
              state    <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          op <= uw.op;
          unique case (uw.op)
            OP_MM_A, OP_MM_PM, OP_MM_G, OP_MM_W, OP_IDENT,
            OP_MM_KG, OP_MM_CORR, OP_MM_P: begin
              i <= '0; j <= '0; k <= '0;
              state <= S_RI;
            end
            OP_COL0: begin
              col   <= '0;
              state <= S_NEXT;
            end
            OP_PIVOT: begin
              r     <= col;
              best  <= col;
              state <= S_PV_RD;
            end
            OP_SWAP: begin
              k     <= '0;
              state <= (best == col) ? S_NEXT : S_SW_R1;
            end
            OP_NORM:  state <= S_NM_RP;
            OP_ELIM: begin
              r     <= '0;
              state <= S_EL_RF;
            end
            OP_NEXTCOL: begin
              col   <= col + IW'(1);
              state <= S_NEXT;
            end
            OP_EMIT: begin
              i     <= '0;
              state <= S_EM_RD;
            end
            default: state <= S_NEXT;
          endcase
        end
        S_NEXT: begin
          state <= S_FETCH;
          case (uw.cond)
            COND_SING: pc <= singular ? uw.target : pc + 4'd1;
            COND_COLS: pc <= (int'(col) < NO) ? uw.target : pc + 4'd1;
            default:   pc <= pc + 4'd1;
          endcase
        end

        // Matrix product element: init, then K multiply-adds, then store.
        S_RI:  state <= S_RIC;
        S_RIC: begin
          if (init_id) begin
            acc <= (i == j) ? 48'sd16777216 : 48'sd0;
          end else if (init_mem) begin
            acc <= 48'(signed'(rdata));
          end else begin
            acc <= '0;
          end
          state <= (lim_k == 0) ? S_WR : S_RA;
        end
        S_RA: state <= S_RB;
        S_RB: begin
          opa   <= rdata;
          bzero <= ((op == OP_MM_A) && !pvalid[pidx]) || ((op == OP_MM_KG) && singular);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= opa * (bzero ? 32'sd0 : signed'(rdata));
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= sub ? (acc - mulq(prod)) : (acc + mulq(prod));
          if (int'(k) + 1 < lim_k) begin
            k     <= k + IW'(1);
            state <= S_RA;
          end else begin
            state <= S_WR;
          end
        end
        S_WR: begin
          if (op == OP_MM_P) begin
            pvalid[PVW'(int'(i) * NS + int'(j))] <= 1'b1;
          end
          k <= '0;
          if (int'(j) + 1 < lim_j) begin
            j     <= j + IW'(1);
            state <= S_RI;
          end else if (int'(i) + 1 < lim_i) begin
            j     <= '0;
            i     <= i + IW'(1);
            state <= S_RI;
          end else begin
            state <= S_NEXT;
          end
        end

        // Pivot search: largest magnitude, the first row wins a tie.
        S_PV_RD: state <= S_PV_CMP;
        S_PV_CMP: begin
          if ((r == col) || (mag > best_mag)) begin
            best     <= r;
            best_mag <= mag;
          end
          if (int'(r) + 1 == NO) begin
            state <= S_PV_END;
          end else begin
            r     <= r + IW'(1);
            state <= S_PV_RD;
          end
        end
        S_PV_END: begin
          if (best_mag == 33'd0) begin
            singular <= 1'b1;
          end
          state <= S_NEXT;
        end

        S_SW_R1: state <= S_SW_R2;
        S_SW_R2: begin
          t1    <= rdata;
          state <= S_SW_W1;
        end
        S_SW_W1: state <= S_SW_W2;
        S_SW_W2: begin
          if (int'(k) + 1 == NC) begin
            state <= S_NEXT;
          end else begin
            k     <= k + IW'(1);
            state <= S_SW_R1;
          end
        end

        S_NM_RP: state <= S_NM_PV;
        S_NM_PV: begin
          piv   <= rdata;
          k     <= '0;
          state <= S_NM_RD;
        end
        S_NM_RD: state <= S_NM_GO;
        S_NM_GO: state <= S_NM_WAIT;
        S_NM_WAIT: begin
          if (div_done) begin
            state <= S_NM_WR;
          end
        end
        S_NM_WR: begin
          if (int'(k) + 1 == NC) begin
            state <= S_NEXT;
          end else begin
            k     <= k + IW'(1);
            state <= S_NM_RD;
          end
        end

        // Elimination: the factor is latched before its row is rewritten.
        S_EL_RF: begin
          if (r == col) begin
            if (int'(r) + 1 == NO) begin
              state <= S_NEXT;
            end else begin
              r <= r + IW'(1);
            end
          end else begin
            state <= S_EL_F;
          end
        end
        S_EL_F: begin
          f     <= rdata;
          k     <= '0;
          state <= S_EL_RM;
        end
        S_EL_RM: state <= S_EL_RC;
        S_EL_RC: begin
          mrk   <= rdata;
          state <= S_EL_MUL;
        end
        S_EL_MUL: begin
          prod  <= f * signed'(rdata);
          state <= S_EL_WR;
        end
        S_EL_WR: begin
          if (int'(k) + 1 < NC) begin
            k     <= k + IW'(1);
            state <= S_EL_RM;
          end else if (int'(r) + 1 == NO) begin
            state <= S_NEXT;
          end else begin
            r     <= r + IW'(1);
            state <= S_EL_RF;
          end
        end

        S_EM_RD: state <= S_EM_OUT;
        S_EM_OUT: begin
          if (int'(i) + 1 == NS) begin
            state <= S_IDLE;
          end else begin
            i     <= i + IW'(1);
            state <= S_EM_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
